FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file tftpc_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, off during reset
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle, off during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle, checked through reset
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/tftpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftpc_pkg
// Types and codes of the TFTP client transfer controller.
// ----------------------------------------------------------------------------
package tftpc_pkg;

  localparam int BLOCK_BYTES_DEF = 512;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_PACKET = 2'd1,
    ACT_TICK   = 2'd2
  } action_t;

  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ACK   = 16'd4;
  localparam logic [15:0] OP_ERROR = 16'd5;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_RRQ    = 3'd1,
    KIND_WRQ    = 3'd2,
    KIND_ACK    = 3'd3,
    KIND_NEW    = 3'd4,
    KIND_RESEND = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_RUN     = 2'd0,
    ST_OK      = 2'd1,
    ST_PEERERR = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] packet_opcode;
    logic [15:0] packet_block;
    logic [9:0]  packet_payload_length;
    logic [15:0] packet_error_code;
    logic [9:0]  source_length;
  } event_t;

  typedef struct packed {
    logic   valid;
    event_t ev;
  } stage_t;

endpackage

FILE: hdl/tftpc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftpc_in_if
// Event channel: valid/ready handshake with the event fields.
// ----------------------------------------------------------------------------
interface tftpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] packet_opcode;
  logic [15:0] packet_block;
  logic [9:0]  packet_payload_length;
  logic [15:0] packet_error_code;
  logic [9:0]  source_length;

  modport source (
    output valid, action, packet_opcode, packet_block, packet_payload_length,
           packet_error_code, source_length,
    input  ready
  );

  modport sink (
    input  valid, action, packet_opcode, packet_block, packet_payload_length,
           packet_error_code, source_length,
    output ready
  );
endinterface

FILE: hdl/tftpc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftpc_out_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface tftpc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  send_kind;
  logic [15:0] send_block;
  logic [9:0]  send_length;
  logic        store_payload;
  logic [1:0]  status;
  logic [15:0] error_code;
  logic [31:0] total_bytes;

  modport source (
    output valid, send_kind, send_block, send_length, store_payload, status,
           error_code, total_bytes,
    input  ready
  );

  modport sink (
    input  valid, send_kind, send_block, send_length, store_payload, status,
           error_code, total_bytes,
    output ready
  );
endinterface

FILE: hdl/tftpc_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftpc_in_stage
// Input register: captures one event transaction per cycle while it is empty or the engine advances.
// ----------------------------------------------------------------------------
module tftpc_in_stage (
  input  logic                clk,
  input  logic                rst,
  tftpc_in_if.sink            events,
  input  logic                advance,
  output tftpc_pkg::stage_t   stage
);

  logic              valid;
  tftpc_pkg::event_t ev;

  assign events.ready = !valid || advance;
  assign stage.valid  = valid;
  assign stage.ev     = ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (events.ready) begin
      valid <= events.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (events.ready && events.valid) begin
      ev.action                <= events.action;
      ev.packet_opcode         <= events.packet_opcode;
      ev.packet_block          <= events.packet_block;
      ev.packet_payload_length <= events.packet_payload_length;
      ev.packet_error_code     <= events.packet_error_code;
      ev.source_length         <= events.source_length;
    end
  end

endmodule

FILE: hdl/tftpc_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftpc_engine
// Transfer state, per-event decision logic and the result register.
// ----------------------------------------------------------------------------
module tftpc_engine #(
  parameter int BLOCK_BYTES = tftpc_pkg::BLOCK_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              direction,
  input  tftpc_pkg::stage_t stage,
  output logic              advance,
  tftpc_out_if.source       results
);

  localparam logic [16:0] BB = 17'(BLOCK_BYTES);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACTIVE = 2'd1,
    PH_ENDED  = 2'd2
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] block_count, block_count_next;
  logic [9:0]  last_sent_length, last_sent_length_next;
  logic [31:0] byte_total, byte_total_next;

  tftpc_pkg::kind_t   kind;
  tftpc_pkg::status_t st;
  logic [15:0] sblock, ecode;
  logic [9:0]  slength, len_rx, len_src, add_len;
  logic        store, add_en, clr;
  logic [15:0] blk_inc, pblk_inc;
  logic [32:0] sum;
  logic        take;

  assign advance = !results.valid || results.ready;
  assign take    = stage.valid && advance;

  assign blk_inc  = block_count + 16'd1;
  assign pblk_inc = stage.ev.packet_block + 16'd1;
  assign len_rx   = ({7'd0, stage.ev.packet_payload_length} > BB) ? BB[9:0]
                                                                  : stage.ev.packet_payload_length;
  assign len_src  = ({7'd0, stage.ev.source_length} > BB) ? BB[9:0]
                                                          : stage.ev.source_length;

  always_comb begin
    logic done;
    done                  = 1'b0;
    kind                  = tftpc_pkg::KIND_NONE;
    st                    = tftpc_pkg::ST_RUN;
    sblock                = 16'd0;
    slength               = 10'd0;
    ecode                 = 16'd0;
    store                 = 1'b0;
    add_en                = 1'b0;
    add_len               = 10'd0;
    clr                   = 1'b0;
    phase_next            = phase;
    block_count_next      = block_count;
    last_sent_length_next = last_sent_length;
    priority if (stage.ev.action == tftpc_pkg::ACT_START) begin
      clr                   = 1'b1;
      phase_next            = PH_ACTIVE;
      block_count_next      = 16'd0;
      last_sent_length_next = 10'd0;
      kind = direction ? tftpc_pkg::KIND_WRQ : tftpc_pkg::KIND_RRQ;
    end else if (phase == PH_ACTIVE && stage.ev.action == tftpc_pkg::ACT_TICK) begin
      if (block_count == 16'd0) begin
        kind = direction ? tftpc_pkg::KIND_WRQ : tftpc_pkg::KIND_RRQ;
      end else if (!direction) begin
        kind   = tftpc_pkg::KIND_ACK;
        sblock = block_count;
      end else begin
        kind    = tftpc_pkg::KIND_RESEND;
        sblock  = block_count;
        slength = last_sent_length;
      end
    end else if (phase == PH_ACTIVE && stage.ev.action == tftpc_pkg::ACT_PACKET) begin
      unique case (stage.ev.packet_opcode)
        tftpc_pkg::OP_DATA: begin
          if (stage.ev.packet_block == blk_inc) begin
            store            = 1'b1;
            add_en           = 1'b1;
            add_len          = len_rx;
            block_count_next = stage.ev.packet_block;
          end
          kind   = tftpc_pkg::KIND_ACK;
          sblock = stage.ev.packet_block;
          if ({7'd0, len_rx} < BB) begin
            st         = tftpc_pkg::ST_OK;
            phase_next = PH_ENDED;
          end
        end
        tftpc_pkg::OP_ACK: begin
          if (block_count == stage.ev.packet_block && stage.ev.packet_block != 16'd0) begin
            add_en  = 1'b1;
            add_len = last_sent_length;
            if ({7'd0, last_sent_length} < BB) begin
              st         = tftpc_pkg::ST_OK;
              phase_next = PH_ENDED;
              done       = 1'b1;
            end
          end
          if (!done) begin
            if (block_count == pblk_inc) begin
              kind    = tftpc_pkg::KIND_RESEND;
              sblock  = block_count;
              slength = last_sent_length;
            end else begin
              block_count_next      = pblk_inc;
              last_sent_length_next = len_src;
              kind                  = tftpc_pkg::KIND_NEW;
              sblock                = pblk_inc;
              slength               = len_src;
            end
          end
        end
        tftpc_pkg::OP_ERROR: begin
          st         = tftpc_pkg::ST_PEERERR;
          ecode      = stage.ev.packet_error_code;
          phase_next = PH_ENDED;
        end
        default: begin
          st         = tftpc_pkg::ST_UNKNOWN;
          phase_next = PH_ENDED;
        end
      endcase
    end else begin
      kind = tftpc_pkg::KIND_NONE;
    end
  end

  // saturating byte total
  assign sum = {1'b0, byte_total} + {23'd0, add_len};
  always_comb begin
    priority if (clr) begin
      byte_total_next = 32'd0;
    end else if (add_en) begin
      byte_total_next = sum[32] ? '1 : sum[31:0];
    end else begin
      byte_total_next = byte_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      block_count      <= 16'd0;
      last_sent_length <= 10'd0;
      byte_total       <= 32'd0;
      results.valid    <= 1'b0;
    end else begin
      if (advance) begin
        results.valid <= stage.valid;
      end
      if (take) begin
        phase                 <= phase_next;
        block_count           <= block_count_next;
        last_sent_length      <= last_sent_length_next;
        byte_total            <= byte_total_next;
        results.send_kind     <= kind;
        results.send_block    <= sblock;
        results.send_length   <= slength;
        results.store_payload <= store;
        results.status        <= st;
        results.error_code    <= ecode;
        results.total_bytes   <= byte_total_next;
      end
    end
  end

endmodule

FILE: hdl/tftp_client_transfer_control_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftp_client_transfer_control_unit
// Controls one TFTP client get or put transfer, one event per transaction.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     content
//  events    in   valid/ready   action, opcode, block, lengths, error code
//  results   out  valid/ready   send command, store strobe, status, total
//  cfg       in   cfg_write     direction (0 get, 1 put)
//
//  One event per cycle sustained while results.ready holds; each event passes
//  through the input register, then decision logic into the result register.
//  rst is synchronous: transfer phase idle, counters zero, direction get.
//  A stalled result holds the engine; an empty input register still takes one
//  more event, then ready drops until results.ready returns.
// ----------------------------------------------------------------------------
module tftp_client_transfer_control_unit #(
  parameter int BLOCK_BYTES = tftpc_pkg::BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  tftpc_in_if.sink    events,
  tftpc_out_if.source results
);

  logic              direction;
  logic              advance;
  tftpc_pkg::stage_t stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
    end else if (cfg_write) begin
      direction <= cfg_data;
    end
  end

  tftpc_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .events  (events),
    .advance (advance),
    .stage   (stage)
  );

  tftpc_engine #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .direction (direction),
    .stage     (stage),
    .advance   (advance),
    .results   (results)
  );

endmodule

FILE: hdl/tftpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftpc_checker
// Port-level checks on the result channel of the transfer controller.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tftpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  send_kind,
  input logic [9:0]  send_length,
  input logic        store_payload,
  input logic [1:0]  status,
  input logic [15:0] error_code,
  input logic [31:0] total_bytes
);

  `ASSERT_NEXT_ALWAYS(a_reset_clears, rst, !out_valid)
  `ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(send_kind) && $stable(total_bytes))
  `ASSERT_SAME(a_store_acks, out_valid && store_payload, send_kind == tftpc_pkg::KIND_ACK && status != tftpc_pkg::ST_PEERERR)
  `ASSERT_SAME(a_errcode_only_peer, out_valid && status != tftpc_pkg::ST_PEERERR, error_code == 16'd0)
  `ASSERT_SAME(a_length_only_data, out_valid && send_length != 10'd0, send_kind == tftpc_pkg::KIND_NEW || send_kind == tftpc_pkg::KIND_RESEND)

endmodule

bind tftp_client_transfer_control_unit tftpc_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .send_kind     (results.send_kind),
  .send_length   (results.send_length),
  .store_payload (results.store_payload),
  .status        (results.status),
  .error_code    (results.error_code),
  .total_bytes   (results.total_bytes)
);

FILE: test/tftp_client_transfer_control_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftp_client_transfer_control_unit_tb
// Self-checking bench for the TFTP client transfer controller. A scoreboard
// class predicts the send command, store strobe, status and byte total of
// every accepted event and checks each result transaction in order. Directed
// get and put sequences come first, then random transfers in both directions
// with bursty events, a stalling result sink and one long sink hold-off.
// ----------------------------------------------------------------------------
typedef enum logic [1:0] {
  PH_IDLE   = 2'd0,
  PH_ACTIVE = 2'd1,
  PH_ENDED  = 2'd2
} xfer_phase_t;

localparam logic [1:0] ACT_RSVD = 2'd3;
localparam int         BLK      = tftpc_pkg::BLOCK_BYTES_DEF;

typedef struct packed {
  tftpc_pkg::kind_t   kind;
  logic [15:0]        blk;
  logic [9:0]         len;
  logic               store;
  tftpc_pkg::status_t status;
  logic [15:0]        ecode;
  logic [31:0]        total;
} send_cmd_t;

class tftp_transfer_scoreboard;
  bit          direction;
  logic [15:0] block_num;
  logic [9:0]  sent_len;
  logic [31:0] moved_bytes;
  xfer_phase_t phase;
  logic [15:0] acked_block;
  send_cmd_t   expected_cmds[$];
  int          mismatches;

  function new();
    direction   = 1'b0;
    block_num   = '0;
    sent_len    = '0;
    moved_bytes = '0;
    phase       = PH_IDLE;
    acked_block = '0;
    mismatches  = 0;
  endfunction

  function logic [9:0] clamp_len(logic [9:0] n);
    return (n > BLK) ? 10'(BLK) : n;
  endfunction

  function void add_bytes(logic [9:0] n);
    logic [32:0] s;
    s = {1'b0, moved_bytes} + 33'(n);
    moved_bytes = s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function send_cmd_t predict_cmd(tftpc_pkg::event_t ev);
    send_cmd_t   c;
    logic [9:0]  len;
    logic [15:0] nxt;
    bit          done;
    c        = '0;
    c.kind   = tftpc_pkg::KIND_NONE;
    c.status = tftpc_pkg::ST_RUN;
    if (ev.action == tftpc_pkg::ACT_START) begin
      block_num   = '0;
      sent_len    = '0;
      moved_bytes = '0;
      acked_block = '0;
      phase       = PH_ACTIVE;
      c.kind      = direction ? tftpc_pkg::KIND_WRQ : tftpc_pkg::KIND_RRQ;
    end else if (phase == PH_ACTIVE && ev.action == tftpc_pkg::ACT_TICK) begin
      if (block_num == 16'd0) begin
        c.kind = direction ? tftpc_pkg::KIND_WRQ : tftpc_pkg::KIND_RRQ;
      end else if (!direction) begin
        c.kind = tftpc_pkg::KIND_ACK;
        c.blk  = block_num;
      end else begin
        c.kind = tftpc_pkg::KIND_RESEND;
        c.blk  = block_num;
        c.len  = sent_len;
      end
    end else if (phase == PH_ACTIVE && ev.action == tftpc_pkg::ACT_PACKET) begin
      if (ev.packet_opcode == tftpc_pkg::OP_DATA) begin
        len = clamp_len(ev.packet_payload_length);
        if (ev.packet_block == 16'(block_num + 16'd1)) begin
          c.store = 1'b1;
          add_bytes(len);
          block_num = ev.packet_block;
        end
        c.kind = tftpc_pkg::KIND_ACK;
        c.blk  = ev.packet_block;
        if (len < BLK) begin
          c.status = tftpc_pkg::ST_OK;
          phase    = PH_ENDED;
        end
      end else if (ev.packet_opcode == tftpc_pkg::OP_ACK) begin
        done        = 1'b0;
        acked_block = ev.packet_block;
        if (block_num == ev.packet_block && ev.packet_block != 16'd0) begin
          add_bytes(sent_len);
          if (sent_len < BLK) begin
            c.status = tftpc_pkg::ST_OK;
            phase    = PH_ENDED;
            done     = 1'b1;
          end
        end
        if (!done) begin
          nxt = ev.packet_block + 16'd1;
          if (block_num == nxt) begin
            c.kind = tftpc_pkg::KIND_RESEND;
          end else begin
            block_num = nxt;
            sent_len  = clamp_len(ev.source_length);
            c.kind    = tftpc_pkg::KIND_NEW;
          end
          c.blk = block_num;
          c.len = sent_len;
        end
      end else if (ev.packet_opcode == tftpc_pkg::OP_ERROR) begin
        c.status = tftpc_pkg::ST_PEERERR;
        c.ecode  = ev.packet_error_code;
        phase    = PH_ENDED;
      end else begin
        c.status = tftpc_pkg::ST_UNKNOWN;
        phase    = PH_ENDED;
      end
    end
    c.total = moved_bytes;
    return c;
  endfunction

  function void note_event(tftpc_pkg::event_t ev);
    expected_cmds.push_back(predict_cmd(ev));
  endfunction

  task report(string msg);
    mismatches++;
    $display("[%0t] ERROR %s", $realtime, msg);
  endtask

  task check_result(send_cmd_t got);
    send_cmd_t exp;
    if (expected_cmds.size() == 0) begin
      report($sformatf("unexpected result transaction %h", got));
    end else begin
      exp = expected_cmds.pop_front();
      if (got.kind !== exp.kind)
        report($sformatf("send_kind got %0d exp %0d", got.kind, exp.kind));
      if (got.blk !== exp.blk)
        report($sformatf("send_block got %0h exp %0h", got.blk, exp.blk));
      if (got.len !== exp.len)
        report($sformatf("send_length got %0d exp %0d", got.len, exp.len));
      if (got.store !== exp.store)
        report($sformatf("store_payload got %0b exp %0b", got.store, exp.store));
      if (got.status !== exp.status)
        report($sformatf("status got %0d exp %0d", got.status, exp.status));
      if (got.ecode !== exp.ecode)
        report($sformatf("error_code got %0h exp %0h", got.ecode, exp.ecode));
      if (got.total !== exp.total)
        report($sformatf("total_bytes got %0d exp %0d", got.total, exp.total));
    end
  endtask
endclass

module tftp_client_transfer_control_unit_tb;

  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;

  logic clk;
  logic rst = 1'b1;
  logic cfg_write;
  logic cfg_data;

  tftpc_in_if  ev_if ();
  tftpc_out_if res_if ();

  tftp_client_transfer_control_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .events    (ev_if),
    .results   (res_if)
  );

  tftp_transfer_scoreboard sb = new();

  int burst_left  = 0;
  int stall_count = 0;
  bit hold_req    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready))
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
  end

  initial begin
    while (stall_count < STALL_LIMIT) @(posedge clk);
    $display("tftp_client_transfer_control_unit_tb NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    send_cmd_t got;
    if (!rst && res_if.valid && res_if.ready) begin
      got.kind   = tftpc_pkg::kind_t'(res_if.send_kind);
      got.blk    = res_if.send_block;
      got.len    = res_if.send_length;
      got.store  = res_if.store_payload;
      got.status = tftpc_pkg::status_t'(res_if.status);
      got.ecode  = res_if.error_code;
      got.total  = res_if.total_bytes;
      sb.check_result(got);
    end
  end

  // result sink: changing stall patterns, plus one long hold-off on request
  initial begin
    int pat_mode;
    int pat_left;
    int cyc;
    pat_mode = 0;
    pat_left = 0;
    cyc      = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 3);
          pat_left = $urandom_range(16, 96);
        end
        pat_left--;
        case (pat_mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= 1'($urandom_range(0, 1));
          2: res_if.ready <= (cyc % 4 == 0);
          default: res_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic tftpc_pkg::event_t mk_event(logic [1:0] act, logic [15:0] op,
                                                 logic [15:0] blk, logic [9:0] plen,
                                                 logic [15:0] perr, logic [9:0] slen);
    tftpc_pkg::event_t ev;
    ev.action                = act;
    ev.packet_opcode         = op;
    ev.packet_block          = blk;
    ev.packet_payload_length = plen;
    ev.packet_error_code     = perr;
    ev.source_length         = slen;
    return ev;
  endfunction

  function automatic tftpc_pkg::event_t rand_event();
    tftpc_pkg::event_t ev;
    int                r;
    int                r2;
    bit                as_data;
    logic [15:0]       bn;
    bn = sb.block_num;
    ev = mk_event(tftpc_pkg::ACT_PACKET, 16'($urandom), 16'($urandom), 10'($urandom),
                  16'($urandom), 10'($urandom));
    r = $urandom_range(0, 99);
    if (sb.phase != PH_ACTIVE) begin
      if (r < 85) ev.action = tftpc_pkg::ACT_START;
      else        ev.action = 2'($urandom_range(1, 3));
      return ev;
    end
    if (r < 3) begin
      ev.action = tftpc_pkg::ACT_START;
    end else if (r < 11) begin
      ev.action = tftpc_pkg::ACT_TICK;
    end else if (r < 13) begin
      ev.action = ACT_RSVD;
    end else if (r < 15) begin
      ev.packet_opcode = tftpc_pkg::OP_ERROR;
    end else if (r >= 17) begin
      as_data = !sb.direction;
      if (r < 21) as_data = !as_data;
      r2 = $urandom_range(0, 99);
      if (as_data) begin
        ev.packet_opcode = tftpc_pkg::OP_DATA;
        if (r2 < 80)      ev.packet_block = bn + 16'd1;
        else if (r2 < 92) ev.packet_block = bn;
        if ($urandom_range(0, 15) != 0) ev.packet_payload_length = 10'(BLK);
      end else begin
        ev.packet_opcode = tftpc_pkg::OP_ACK;
        if (r2 < 80)      ev.packet_block = bn;
        else if (r2 < 92) ev.packet_block = bn - 16'd1;
        if ($urandom_range(0, 15) != 0) ev.source_length = 10'(BLK);
      end
    end
    return ev;
  endfunction

  task automatic send_event(tftpc_pkg::event_t ev);
    if (burst_left == 0) begin
      ev_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
    end
    ev_if.valid                 <= 1'b1;
    ev_if.action                <= ev.action;
    ev_if.packet_opcode         <= ev.packet_opcode;
    ev_if.packet_block          <= ev.packet_block;
    ev_if.packet_payload_length <= ev.packet_payload_length;
    ev_if.packet_error_code     <= ev.packet_error_code;
    ev_if.source_length         <= ev.source_length;
    do @(posedge clk); while (!ev_if.ready);
    sb.note_event(ev);
    burst_left--;
  endtask

  task automatic drain();
    ev_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic set_direction(bit dir);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= dir;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.direction = dir;
  endtask

  task automatic run_random(int n);
    tftpc_pkg::event_t ev;
    int                cnt;
    bit                counts;
    cnt = 0;
    while (cnt < n) begin
      ev     = rand_event();
      counts = (sb.phase == PH_ACTIVE) || (ev.action == tftpc_pkg::ACT_START);
      send_event(ev);
      if (counts) cnt++;
    end
  endtask

  initial begin
    cfg_write                   <= 1'b0;
    cfg_data                    <= 1'b0;
    ev_if.valid                 <= 1'b0;
    ev_if.action                <= tftpc_pkg::ACT_START;
    ev_if.packet_opcode         <= '0;
    ev_if.packet_block          <= '0;
    ev_if.packet_payload_length <= '0;
    ev_if.packet_error_code     <= '0;
    ev_if.source_length         <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // get transfers
    set_direction(1'b0);
    send_event(mk_event(tftpc_pkg::ACT_TICK, tftpc_pkg::OP_DATA, 16'd1, 10'd512, 16'd0, 10'd0));
    send_event(mk_event(tftpc_pkg::ACT_PACKET, tftpc_pkg::OP_DATA, 16'd1, 10'd512, 16'd0,
                        10'd0));
    send_event(mk_event(tftpc_pkg::ACT_START, 16'd0, 16'd0, 10'd0, 16'd0, 10'd0));
    send_event(mk_event(tftpc_pkg::ACT_TICK, 16'd0, 16'd0, 10'd0, 16'd0, 10'd0));
    send_event(mk_event(tftpc_pkg::ACT_PACKET, tftpc_pkg::OP_DATA, 16'd1, 10'd512, 16'd0,
                        10'd0));
    send_event(mk_event(tftpc_pkg::ACT_PACKET, tftpc_pkg::OP_DATA, 16'd1, 10'd512, 16'd0,
                        10'd0));
    send_event(mk_event(tftpc_pkg::ACT_TICK, 16'd0, 16'd0, 10'd0, 16'd0, 10'd0));
    send_event(mk_event(tftpc_pkg::ACT_PACKET, tftpc_pkg::OP_DATA, 16'd2, 10'h3FF, 16'd0,
                        10'h3FF));
    send_event(mk_event(ACT_RSVD, tftpc_pkg::OP_DATA, 16'd3, 10'd0, 16'd0, 10'd0));
    send_event(mk_event(tftpc_pkg::ACT_PACKET, tftpc_pkg::OP_DATA, 16'd3, 10'd0, 16'd0,
                        10'd0));
    send_event(mk_event(tftpc_pkg::ACT_PACKET, tftpc_pkg::OP_DATA, 16'd4, 10'd512, 16'd0,
                        10'd0));
    send_event(mk_event(tftpc_pkg::ACT_START, 16'd0, 16'd0, 10'd0, 16'd0, 10'd0));
    send_event(mk_event(tftpc_pkg::ACT_PACKET, tftpc_pkg::OP_ERROR, 16'hFFFF, 10'd0,
                        16'hFFFF, 10'd0));
    send_event(mk_event(tftpc_pkg::ACT_START, 16'd0, 16'd0, 10'd0, 16'd0, 10'd0));
    send_event(mk_event(tftpc_pkg::ACT_PACKET, 16'hFFFF, 16'd0, 10'd0, 16'd0, 10'd0));
    send_event(mk_event(tftpc_pkg::ACT_START, 16'd0, 16'd0, 10'd0, 16'd0, 10'd0));
    send_event(mk_event(tftpc_pkg::ACT_PACKET, tftpc_pkg::OP_ACK, 16'd0, 10'd0, 16'd0,
                        10'd512));
    send_event(mk_event(tftpc_pkg::ACT_PACKET, tftpc_pkg::OP_DATA, 16'd2, 10'd511, 16'd0,
                        10'd0));

    // put transfers, including a block number wrap
    set_direction(1'b1);
    send_event(mk_event(tftpc_pkg::ACT_START, 16'd0, 16'd0, 10'd0, 16'd0, 10'd0));
    send_event(mk_event(tftpc_pkg::ACT_TICK, 16'd0, 16'd0, 10'd0, 16'd0, 10'd0));
    send_event(mk_event(tftpc_pkg::ACT_PACKET, tftpc_pkg::OP_ACK, 16'd0, 10'd0, 16'd0,
                        10'd512));
    send_event(mk_event(tftpc_pkg::ACT_PACKET, tftpc_pkg::OP_ACK, 16'd0, 10'd0, 16'd0,
                        10'd512));
    send_event(mk_event(tftpc_pkg::ACT_TICK, 16'd0, 16'd0, 10'd0, 16'd0, 10'd0));
    send_event(mk_event(tftpc_pkg::ACT_PACKET, tftpc_pkg::OP_ACK, 16'd1, 10'd0, 16'd0,
                        10'h3FF));
    send_event(mk_event(tftpc_pkg::ACT_PACKET, tftpc_pkg::OP_ACK, 16'hFFFE, 10'd0, 16'd0,
                        10'd0));
    send_event(mk_event(tftpc_pkg::ACT_PACKET, tftpc_pkg::OP_DATA, 16'd0, 10'd512, 16'd0,
                        10'd0));
    send_event(mk_event(tftpc_pkg::ACT_PACKET, tftpc_pkg::OP_ACK, 16'd7, 10'd0, 16'd0,
                        10'd10));
    send_event(mk_event(tftpc_pkg::ACT_PACKET, tftpc_pkg::OP_ACK, 16'd8, 10'd0, 16'd0,
                        10'd0));
    send_event(mk_event(tftpc_pkg::ACT_START, 16'd0, 16'd0, 10'd0, 16'd0, 10'd0));
    send_event(mk_event(tftpc_pkg::ACT_PACKET, tftpc_pkg::OP_ERROR, 16'd0, 10'd0, 16'd0,
                        10'd0));

    for (int ph = 0; ph < 6; ph++) begin
      set_direction(ph[0]);
      if (ph == 2) hold_req = 1'b1;
      run_random(280);
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.expected_cmds.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_cmds.size()));
    if (sb.mismatches == 0)
      $display("tftp_client_transfer_control_unit_tb OK");
    else
      $display("tftp_client_transfer_control_unit_tb NOT OK");
    $finish;
  end

endmodule
